FILE: rtl/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg - shared types and constants for the sliding window minimum unit
// Sample width, window depth and the per-cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int WINDOW_MAX = 1024;
  localparam int LEN_W      = $clog2(WINDOW_MAX + 1);
  localparam int IDX_W      = $clog2(WINDOW_MAX);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [LEN_W-1:0]           len_t;
  typedef logic [IDX_W-1:0]           idx_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam len_t    LEN_ONE    = len_t'(1);
  localparam len_t    LEN_MAX    = len_t'(WINDOW_MAX);
  localparam idx_t    IDX_LAST   = idx_t'(WINDOW_MAX - 1);

  // Broadcast to every cell: advance strobe and the value being pushed in.
  typedef struct packed {
    logic    step;
    sample_t x;
  } chain_ctrl_t;

  function automatic sample_t smin(input sample_t a, input sample_t b);
    smin = (a < b) ? a : b;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/swm_cell.sv
// ----------------------------------------------------------------------------
// swm_cell - one stage of the minimum chain
// Holds one raw sample (shift line) and one partial minimum (w). On a step the
// sample moves one cell down and w takes min(x, neighbor w), or x when trunc.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_cell
  import swm_pkg::*;
(
  input  wire logic        clk,
  input  wire chain_ctrl_t ctrl,
  input  wire sample_t     s_in,
  input  wire sample_t     w_in,
  input  wire logic        trunc,   // cell sits at or past the window edge
  output sample_t          s_out,
  output sample_t          w_out,
  output sample_t          w_nxt
);

  sample_t s_r;
  sample_t w_r;

  assign w_nxt = smin(ctrl.x, trunc ? SAMPLE_MAX : w_in);
  assign s_out = s_r;
  assign w_out = w_r;

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      s_r <= s_in;
      w_r <= w_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/swm_chain.sv
// ----------------------------------------------------------------------------
// swm_chain - row of WINDOW_MAX cells
// Samples flow toward the tail, partial minima flow toward the head. Cell k
// holds the minimum of the last (len - k) samples.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_chain
  import swm_pkg::*;
(
  input  wire logic        clk,
  input  wire chain_ctrl_t ctrl,
  input  wire len_t        len_eff,
  output sample_t          s_tail,    // oldest stored sample
  output sample_t          head_min   // minimum of the window including ctrl.x
);

  sample_t s_q    [WINDOW_MAX];
  sample_t w_q    [WINDOW_MAX];
  sample_t wnxt_q [WINDOW_MAX];

  for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
    localparam len_t CELL_SPAN = len_t'(k + 1);
    sample_t s_in;
    sample_t w_in;
    logic    trunc;

    if (k == 0) begin : g_head
      assign s_in = ctrl.x;
    end else begin : g_body
      assign s_in = s_q[k-1];
    end

    if (k == WINDOW_MAX - 1) begin : g_tail
      assign w_in = SAMPLE_MAX;
    end else begin : g_mid
      assign w_in = w_q[k+1];
    end

    assign trunc = (len_eff <= CELL_SPAN);

    swm_cell u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .s_in  (s_in),
      .w_in  (w_in),
      .trunc (trunc),
      .s_out (s_q[k]),
      .w_out (w_q[k]),
      .w_nxt (wnxt_q[k])
    );
  end

  assign s_tail   = s_q[WINDOW_MAX-1];
  assign head_min = wnxt_q[0];

endmodule

`default_nettype wire

FILE: rtl/sliding_window_minimum_unit.sv
// ----------------------------------------------------------------------------
// sliding_window_minimum_unit - streaming minimum over the last window_len
// samples of a sequence
// ----------------------------------------------------------------------------
// One signed 32-bit sample per input transfer; in_tuser flags the first sample
// of a sequence, in_tlast the last. Once window_len samples of the current
// sequence have been taken, each sample yields one result transfer carrying
// the window minimum, with out_tlast copied from in_tlast. The unit takes one
// sample per clock unless rebuilding or holding a stalled result; a result
// appears on the cycle after its sample. The window lives in a row of 1024
// cells: each cell keeps one raw sample and the minimum of a shrinking span
// of the most recent samples, so the head cell gives the answer with one
// compare. A window_len write re-derives those spans by rotating the stored
// samples once through the row; in_tready and cfg_ready stay low until it
// ends. window_len 0 acts as 1, values above 1024 act as 1024.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_minimum_unit
  import swm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,

  // sample input
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] sample
  input  wire logic        in_tuser,   // [0] seq_start
  input  wire logic        in_tlast,   // seq_end

  // result output
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] window_min
  output logic             out_tlast,  // is_last

  // window_len register write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [10:0] cfg_data    // window_len
);

  // --------------------------------------------------------------------------
  // Configuration and rebuild sequencer
  // --------------------------------------------------------------------------
  len_t len_eff_r, len_eff_nxt;
  logic busy_r,    busy_nxt;
  idx_t rb_cnt_r,  rb_cnt_nxt;

  logic cfg_xfer;
  logic in_xfer;

  assign cfg_ready = !busy_r;
  assign cfg_xfer  = cfg_valid && cfg_ready;

  // Clamp once at write time so the cells see a legal length.
  always_comb begin
    len_eff_nxt = len_eff_r;
    if (cfg_xfer) begin
      priority if (cfg_data == '0)          len_eff_nxt = LEN_ONE;
      else if (len_t'(cfg_data) > LEN_MAX)  len_eff_nxt = LEN_MAX;
      else                                  len_eff_nxt = len_t'(cfg_data);
    end
  end

  // Rebuild: replay all stored samples oldest first so every cell's span
  // matches the new length; the rotation leaves the shift line as it was.
  always_comb begin
    busy_nxt   = busy_r;
    rb_cnt_nxt = rb_cnt_r;
    if (cfg_xfer) begin
      busy_nxt   = 1'b1;
      rb_cnt_nxt = '0;
    end else if (busy_r) begin
      rb_cnt_nxt = rb_cnt_r + idx_t'(1);
      if (rb_cnt_r == IDX_LAST) busy_nxt = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Cell row
  // --------------------------------------------------------------------------
  chain_ctrl_t ctrl;
  sample_t     s_tail;
  sample_t     head_min;

  assign ctrl.step = busy_r || in_xfer;
  assign ctrl.x    = busy_r ? s_tail : sample_t'(in_tdata);

  swm_chain u_chain (
    .clk      (clk),
    .ctrl     (ctrl),
    .len_eff  (len_eff_r),
    .s_tail   (s_tail),
    .head_min (head_min)
  );

  // --------------------------------------------------------------------------
  // Sequence fill tracking
  // --------------------------------------------------------------------------
  len_t fill_r, fill_nxt;
  len_t fill_base;
  len_t fill_inc;
  logic produce;

  assign fill_base = in_tuser ? '0 : fill_r;
  assign fill_inc  = (fill_base < LEN_MAX) ? fill_base + LEN_ONE : fill_base;
  assign produce   = (fill_inc >= len_eff_r);

  always_comb begin
    fill_nxt = fill_r;
    if (in_xfer) fill_nxt = in_tlast ? '0 : fill_inc;
  end

  // --------------------------------------------------------------------------
  // Output register: a new sample is taken whenever no rebuild runs and the
  // slot is empty or being drained in the same cycle.
  // --------------------------------------------------------------------------
  logic    out_valid_r, out_valid_nxt;
  sample_t out_min_r;
  logic    out_last_r;

  assign in_tready = !busy_r && (!out_valid_r || out_tready);
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_xfer)         out_valid_nxt = produce;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_eff_r   <= LEN_ONE;
      busy_r      <= 1'b0;
      rb_cnt_r    <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      len_eff_r   <= len_eff_nxt;
      busy_r      <= busy_nxt;
      rb_cnt_r    <= rb_cnt_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_min_r  <= head_min;
      out_last_r <= in_tlast;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_min_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

FILE: rtl/swm_checker.sv
// ----------------------------------------------------------------------------
// swm_checker - port-level checks for the sliding window minimum unit
// Bound onto the top level; watches handshakes and result timing.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic        out_tlast,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready
);

  // Held result must not change while stalled.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // A stalled result blocks new samples.
  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("sample taken while result stalled");

  // Results only come from accepted samples.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && !(in_tvalid && in_tready) |=> !out_tvalid)
    else $error("result without a sample transfer");

  // A length write starts the rebuild: no samples or writes next cycle.
  a_cfg_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> !in_tready && !cfg_ready)
    else $error("unit not busy after length write");

endmodule

bind sliding_window_minimum_unit swm_checker u_swm_checker (.*);

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - sliding window minimum unit
// Streams sequences of signed samples through the unit under several window
// lengths, predicts each window minimum in parallel and compares every result
// transfer field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------

module testbench;
  import swm_pkg::*;

  localparam int          ITEMS       = 1700;     // stimulus stops past this count
  localparam int          DRAIN_PAUSE = 8;        // idle wait after the last result
  localparam int          HOLD_CYCLES = 400;      // long receiver hold-off
  localparam int unsigned LIMIT       = 500000;   // cycle budget for the run
  localparam sample_t     S_MIN       = ~SAMPLE_MAX;

  // Directed rows: a window_len write, a sample checked by the predictor, or a
  // sample whose result is typed in (window of one returns the sample itself).
  typedef enum logic [1:0] {ROW_SAMPLE, ROW_TYPED, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    len_t      cfg_len;
    sample_t   s;
    logic      st;
    logic      en;
    sample_t   want;
  } dir_row_t;

  typedef struct packed {
    logic    hit;
    sample_t min_val;
    logic    last;
  } min_res_t;

  localparam int DIR_ROWS = 30;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // window 1 after reset; first sample carries no start mark
    '{ROW_TYPED,  11'd0,    S_MIN,        1'b0, 1'b0, S_MIN},
    '{ROW_TYPED,  11'd0,    SAMPLE_MAX,   1'b1, 1'b0, SAMPLE_MAX},
    '{ROW_TYPED,  11'd0,    32'sd0,       1'b0, 1'b1, 32'sd0},
    // no start mark right after an end mark
    '{ROW_TYPED,  11'd0,    -32'sd1,      1'b0, 1'b0, -32'sd1},
    '{ROW_TYPED,  11'd0,    32'sd1,       1'b0, 1'b1, 32'sd1},
    '{ROW_CFG,    11'd3,    32'sd0,       1'b0, 1'b0, 32'sd0},
    '{ROW_SAMPLE, 11'd0,    32'sd5,       1'b1, 1'b0, 32'sd0},
    '{ROW_SAMPLE, 11'd0,    -32'sd7,      1'b0, 1'b0, 32'sd0},
    '{ROW_SAMPLE, 11'd0,    32'sd3,       1'b0, 1'b0, 32'sd0},
    '{ROW_SAMPLE, 11'd0,    32'sd8,       1'b0, 1'b0, 32'sd0},
    '{ROW_SAMPLE, 11'd0,    32'sd9,       1'b0, 1'b0, 32'sd0},
    '{ROW_SAMPLE, 11'd0,    SAMPLE_MAX,   1'b0, 1'b1, 32'sd0},
    // two-sample sequence, shorter than the window: no result
    '{ROW_SAMPLE, 11'd0,    32'sd4,       1'b1, 1'b0, 32'sd0},
    '{ROW_SAMPLE, 11'd0,    32'sd2,       1'b0, 1'b1, 32'sd0},
    '{ROW_SAMPLE, 11'd0,    32'sd10,      1'b0, 1'b0, 32'sd0},
    '{ROW_SAMPLE, 11'd0,    32'sd11,      1'b0, 1'b0, 32'sd0},
    '{ROW_SAMPLE, 11'd0,    32'sd12,      1'b0, 1'b0, 32'sd0},
    // window grows mid-sequence past the fill count
    '{ROW_CFG,    11'd5,    32'sd0,       1'b0, 1'b0, 32'sd0},
    '{ROW_SAMPLE, 11'd0,    32'sd1,       1'b0, 1'b0, 32'sd0},
    '{ROW_SAMPLE, 11'd0,    32'sd6,       1'b0, 1'b0, 32'sd0},
    // restart mark in the middle of a running sequence
    '{ROW_SAMPLE, 11'd0,    S_MIN,        1'b1, 1'b0, 32'sd0},
    '{ROW_SAMPLE, 11'd0,    SAMPLE_MAX,   1'b0, 1'b0, 32'sd0},
    '{ROW_SAMPLE, 11'd0,    -32'sd1,      1'b0, 1'b1, 32'sd0},
    // zero length behaves as one
    '{ROW_CFG,    11'd0,    32'sd0,       1'b0, 1'b0, 32'sd0},
    '{ROW_TYPED,  11'd0,    -32'sd3,      1'b1, 1'b1, -32'sd3},
    // over-range length clamps to the full depth
    '{ROW_CFG,    11'd2047, 32'sd0,       1'b0, 1'b0, 32'sd0},
    '{ROW_SAMPLE, 11'd0,    32'sd5,       1'b1, 1'b1, 32'sd0},
    '{ROW_CFG,    11'd2,    32'sd0,       1'b0, 1'b0, 32'sd0},
    '{ROW_SAMPLE, 11'd0,    S_MIN,        1'b1, 1'b0, 32'sd0},
    '{ROW_SAMPLE, 11'd0,    S_MIN,        1'b0, 1'b1, 32'sd0}
  };

  // --------------------------------------------------------------------------
  // Clock, reset, DUT ports
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;     // [31:0] sample
  logic        in_tuser = 1'b0;   // [0] seq_start
  logic        in_tlast = 1'b0;   // seq_end

  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // [31:0] window_min
  logic        out_tlast;         // is_last

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [10:0] cfg_data = '0;     // window_len

  always #5 clk = ~clk;

  sliding_window_minimum_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Window predictor: own copy of the sample ring, fill count and length
  // --------------------------------------------------------------------------
  sample_t     recent [WINDOW_MAX];
  int unsigned taken_cnt = 0;
  idx_t        next_slot = '0;
  len_t        len_reg   = LEN_ONE;

  min_res_t    mins_due [$];      // predicted minima not yet seen on the output
  min_res_t    head_due;
  int          mismatches   = 0;
  int          samples_taken = 0;
  int unsigned cycles       = 0;

  bit          calm     = 1'b0;   // both sides stop idling while set
  bit          hold_req = 1'b0;
  logic        hold_on  = 1'b0;

  // Length as the unit applies it: 0 acts as 1, above depth acts as depth.
  function automatic int unsigned eff_len(len_t v);
    if (v == '0) return 1;
    if (v > LEN_MAX) return WINDOW_MAX;
    return int'(v);
  endfunction

  function automatic min_res_t slide_min_step(sample_t s, logic st, logic en);
    min_res_t    r;
    int unsigned span;
    idx_t        slot;
    sample_t     best;
    span = eff_len(len_reg);
    r    = '0;
    if (st) taken_cnt = 0;
    recent[next_slot] = s;
    next_slot = next_slot + 1'b1;
    if (taken_cnt < WINDOW_MAX) taken_cnt++;
    if (taken_cnt >= span) begin
      best = s;
      // walk back from the newest entry over span-1 older samples
      for (int i = 1; i < span; i++) begin
        slot = next_slot - idx_t'(1 + i);
        if (recent[slot] < best) best = recent[slot];
      end
      r.hit     = 1'b1;
      r.min_val = best;
      r.last    = en;
    end
    if (en) taken_cnt = 0;   // end mark empties the window
    return r;
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // Offers one sample, holding valid until the transfer completes. The
  // expectation is queued in the same step as the transfer; the result cannot
  // come out before the next edge.
  task automatic send_sample(sample_t s, logic st, logic en, logic typed, sample_t want);
    min_res_t r;
    while (!calm && $urandom_range(99) < 22) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    in_tuser  <= st;
    in_tlast  <= en;
    do @(posedge clk); while (!in_tready);
    samples_taken++;
    r = slide_min_step(s, st, en);
    if (typed) mins_due.push_back('{1'b1, want, en});
    else if (r.hit) mins_due.push_back(r);
  endtask

  // Unit is idle once every predicted result has arrived and a sample that
  // makes no result has had time to pass through.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (mins_due.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic write_window_len(len_t v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    len_reg = v;
  endtask

  function automatic sample_t corner_sample();
    case ($urandom_range(3))
      0:       return S_MIN;
      1:       return SAMPLE_MAX;
      2:       return '0;
      default: return -32'sd1;
    endcase
  endfunction

  // One sequence with random content. Mostly well formed (start mark first,
  // end mark last, long enough to fill a window of at most 200); sometimes
  // cut short, missing its marks, or hit by a stray start or end midway.
  task automatic send_run(int unsigned span);
    int unsigned n;
    int          flavor;
    logic        st0, en_last, st, en;
    sample_t     base, stride, s;
    if (span > 200) n = $urandom_range(1, 16);
    else if ($urandom_range(99) < 75) n = $urandom_range(span, span + 12);
    else n = $urandom_range(1, span);
    st0     = ($urandom_range(99) < 85);
    en_last = ($urandom_range(99) < 88);
    flavor  = $urandom_range(4);
    base    = $urandom;
    stride  = sample_t'($urandom_range(1000)) - 32'sd500;
    for (int k = 0; k < n; k++) begin
      case (flavor)
        0:       s = $urandom;
        1:       s = sample_t'($urandom_range(16)) - 32'sd8;   // many ties
        2:       s = corner_sample();
        default: s = base + sample_t'(k) * stride;             // ramps
      endcase
      st = (k == 0 && st0) || ($urandom_range(99) == 0);
      en = (k == n - 1 && en_last) || ($urandom_range(199) == 0);
      send_sample(s, st, en, 1'b0, '0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Output side: random stalls, long hold-off on request, result checks
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_tready <= !hold_on && (calm || $urandom_range(99) >= 22);
    if (out_tvalid && out_tready) begin
      if (mins_due.size() == 0) begin
        report_mismatch($sformatf("result %0d with none pending", $signed(out_tdata)));
      end else begin
        head_due = mins_due.pop_front();
        if (out_tdata !== head_due.min_val)
          report_mismatch($sformatf("window_min %0d, predicted %0d",
                                    $signed(out_tdata), head_due.min_val));
        if (out_tlast !== head_due.last)
          report_mismatch($sformatf("is_last %b, predicted %b", out_tlast, head_due.last));
      end
    end
  end

  // Receiver stops for a long stretch while the sender keeps offering, so
  // the unit backs up and drops in_tready.
  initial begin
    wait (hold_req);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int      v;
    int      roll;
    int      long_n, tail_n;
    bit      long_done;
    sample_t ramp_base, s;
    long_done = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int d = 0; d < DIR_ROWS; d++) begin
      if (DIR_TABLE[d].kind == ROW_CFG)
        write_window_len(DIR_TABLE[d].cfg_len);
      else
        send_sample(DIR_TABLE[d].s, DIR_TABLE[d].st, DIR_TABLE[d].en,
                    DIR_TABLE[d].kind == ROW_TYPED, DIR_TABLE[d].want);
    end

    // random phases, each under one window length
    while (samples_taken < ITEMS) begin
      if (!long_done && samples_taken >= 300) begin
        // One sequence longer than the ring: small window first (results on
        // every sample, the hold-off and a calm stretch land here), then the
        // full depth so the fill count saturates and the ring wraps. An
        // ascending ramp puts the minimum on the oldest sample of the window.
        long_done = 1'b1;
        ramp_base = sample_t'($urandom_range(1 << 20)) - 32'sd400000;
        long_n    = $urandom_range(1000, 1010);
        tail_n    = $urandom_range(40, 70);
        write_window_len(len_t'($urandom_range(2, 12)));
        for (int k = 0; k < long_n; k++) begin
          if (k == 50) hold_req = 1'b1;
          calm = (k >= 600 && k < 900);
          s = ($urandom_range(9) == 0) ? sample_t'($urandom) : ramp_base + sample_t'(3 * k);
          send_sample(s, k == 0, 1'b0, 1'b0, '0);
        end
        calm = 1'b0;
        // length change mid-sequence, at or beyond the depth
        write_window_len(($urandom_range(1) == 0) ? LEN_MAX
                                                  : len_t'($urandom_range(1025, 2047)));
        for (int k = 0; k < tail_n; k++) begin
          s = ramp_base + sample_t'(3 * (long_n + k));
          send_sample(s, 1'b0, k == tail_n - 1, 1'b0, '0);
        end
      end

      roll = $urandom_range(99);
      if (roll < 55)      v = $urandom_range(1, 8);
      else if (roll < 75) v = $urandom_range(9, 64);
      else if (roll < 82) v = $urandom_range(65, 200);
      else if (roll < 88) v = 0;
      else if (roll < 94) v = WINDOW_MAX;
      else                v = $urandom_range(1025, 2047);
      write_window_len(len_t'(v));
      repeat ($urandom_range(1, 6)) send_run(eff_len(len_reg));
    end

    settle();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
